// ----- src/lfu_pkg.sv -----
// Shared constants and controller/datapath interface types for the LFU page replacement unit.
`timescale 1ns / 1ps
`default_nettype none
package lfu_pkg;

  localparam int MAX_FRAMES = 16;
  localparam int FRAME_BITS = $clog2(MAX_FRAMES);
  localparam int CFG_BITS   = 5;
  localparam int PAGE_BITS  = 16;
  localparam int USES_BITS  = 16;
  localparam int COUNT_BITS = 32;
  localparam int ADDR_BITS  = 3;
  localparam int DATA_BITS  = 32;

  localparam logic [CFG_BITS-1:0] FRAMES_RESET = CFG_BITS'(MAX_FRAMES);
  localparam logic                REG_FRAMES_IN_USE = 1'b0;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } lfu_cmd_t;

  typedef struct packed {
    logic match;
    logic last;
  } lfu_sts_t;

endpackage
`default_nettype wire

// ----- src/lfu_ctrl.sv -----
// Sequencer for one page reference: load, scan frames, commit the update.
`timescale 1ns / 1ps
`default_nettype none
module lfu_ctrl
  import lfu_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  lfu_sts_t      sts_i,
  output lfu_cmd_t      cmd_o,
  output logic          busy_o
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StScan   = 2'd1;
  localparam logic [1:0] StCommit = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = StScan;
        end
      end
      StScan: begin
        cmd_o.step = 1'b1;
        // stop at the first matching frame or after the last active one
        if (sts_i.match || sts_i.last) begin
          state_d = StCommit;
        end
      end
      StCommit: begin
        cmd_o.commit = 1'b1;
        state_d      = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != StIdle);

endmodule
`default_nettype wire

// ----- src/lfu_datapath.sv -----
// Frame table, scan registers, saturating counters and result register.
`timescale 1ns / 1ps
`default_nettype none
module lfu_datapath
  import lfu_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  lfu_cmd_t                   cmd_i,
  output lfu_sts_t                   sts_o,
  input  wire logic [CFG_BITS-1:0]   frames_in_use_i,
  input  wire logic [PAGE_BITS-1:0]  page_id_i,
  output logic                       res_valid_o,
  output logic                       hit_o,
  output logic [FRAME_BITS-1:0]      frame_index_o,
  output logic [COUNT_BITS-1:0]      fault_total_o,
  output logic [COUNT_BITS-1:0]      hit_total_o
);

  logic [PAGE_BITS-1:0]  page_mem [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] valid_q;
  logic [USES_BITS-1:0]  uses_q   [MAX_FRAMES];
  logic [COUNT_BITS-1:0] stamp_q  [MAX_FRAMES];

  logic [COUNT_BITS-1:0] stamp_ctr_q, stamp_ctr_d;
  logic [COUNT_BITS-1:0] fault_ctr_q, fault_ctr_d;
  logic [COUNT_BITS-1:0] hit_ctr_q, hit_ctr_d;

  logic [PAGE_BITS-1:0]  page_q;
  logic [FRAME_BITS-1:0] idx_q;
  logic                  found_q;
  logic [FRAME_BITS-1:0] hit_slot_q;
  logic                  empty_q;
  logic [FRAME_BITS-1:0] empty_slot_q;
  logic [FRAME_BITS-1:0] vic_slot_q;
  logic [USES_BITS-1:0]  vic_uses_q;
  logic [COUNT_BITS-1:0] vic_stamp_q;

  logic [FRAME_BITS-1:0] last_idx;
  logic                  cur_valid;
  logic                  cur_match;
  logic                  cur_less;
  logic [FRAME_BITS-1:0] new_slot;

  // clamp the configured count into 1..MAX_FRAMES
  always_comb begin
    if (frames_in_use_i == '0) begin
      last_idx = '0;
    end else if (frames_in_use_i > CFG_BITS'(MAX_FRAMES)) begin
      last_idx = FRAME_BITS'(MAX_FRAMES - 1);
    end else begin
      last_idx = FRAME_BITS'(frames_in_use_i - CFG_BITS'(1));
    end
  end

  assign cur_valid = valid_q[idx_q];
  assign cur_match = cur_valid && (page_mem[idx_q] == page_q);
  assign cur_less  = (uses_q[idx_q] < vic_uses_q) ||
                     ((uses_q[idx_q] == vic_uses_q) && (stamp_q[idx_q] < vic_stamp_q));

  assign sts_o.match = cur_match;
  assign sts_o.last  = (idx_q == last_idx);

  assign new_slot    = empty_q ? empty_slot_q : vic_slot_q;
  assign stamp_ctr_d = (&stamp_ctr_q) ? stamp_ctr_q : stamp_ctr_q + COUNT_BITS'(1);
  assign fault_ctr_d = (&fault_ctr_q) ? fault_ctr_q : fault_ctr_q + COUNT_BITS'(1);
  assign hit_ctr_d   = (&hit_ctr_q) ? hit_ctr_q : hit_ctr_q + COUNT_BITS'(1);

  // scan registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      page_q  <= page_id_i;
      idx_q   <= '0;
      found_q <= 1'b0;
      empty_q <= 1'b0;
    end else if (cmd_i.step) begin
      idx_q <= idx_q + FRAME_BITS'(1);
      if (cur_match) begin
        found_q    <= 1'b1;
        hit_slot_q <= idx_q;
      end
      if (!cur_valid && !empty_q) begin
        empty_q      <= 1'b1;
        empty_slot_q <= idx_q;
      end
      // frame zero seeds the victim; later frames replace it only when strictly less used, or equally used and older
      if ((idx_q == '0) || cur_less) begin
        vic_slot_q  <= idx_q;
        vic_uses_q  <= uses_q[idx_q];
        vic_stamp_q <= stamp_q[idx_q];
      end
    end
  end

  // page tags carry no reset; they are read only behind a valid bit
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && !found_q) begin
      page_mem[new_slot] <= page_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      uses_q      <= '{default: '0};
      stamp_q     <= '{default: '0};
      stamp_ctr_q <= '0;
      fault_ctr_q <= '0;
      hit_ctr_q   <= '0;
      res_valid_o <= 1'b0;
    end else begin
      res_valid_o <= cmd_i.commit;
      if (cmd_i.commit) begin
        if (found_q) begin
          hit_ctr_q <= hit_ctr_d;
          if (!(&uses_q[hit_slot_q])) begin
            uses_q[hit_slot_q] <= uses_q[hit_slot_q] + USES_BITS'(1);
          end
          if (!(&stamp_q[hit_slot_q])) begin
            stamp_q[hit_slot_q] <= stamp_q[hit_slot_q] + COUNT_BITS'(1);
          end
        end else begin
          fault_ctr_q        <= fault_ctr_d;
          stamp_ctr_q        <= stamp_ctr_d;
          valid_q[new_slot]  <= 1'b1;
          uses_q[new_slot]   <= USES_BITS'(1);
          stamp_q[new_slot]  <= stamp_ctr_d;
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      hit_o         <= found_q;
      frame_index_o <= found_q ? hit_slot_q : new_slot;
      fault_total_o <= found_q ? fault_ctr_q : fault_ctr_d;
      hit_total_o   <= found_q ? hit_ctr_d : hit_ctr_q;
    end
  end

endmodule
`default_nettype wire

// ----- src/lfu_page_replacement_unit.sv -----
// Top level of the LFU page replacement unit: register port, controller and datapath.
//
// Usage: drive page_id_i and raise start; the reference is taken at a rising edge
// where start is high and busy is low. The unit scans the active frames one per
// cycle, stopping at the first resident copy of the page; on a miss the same pass
// finds the lowest empty frame or the least-used, oldest frame to replace.
// A commit state then applies the update, and the result (hit_o, frame_index_o,
// fault_total_o, hit_total_o) appears with res_valid_o for exactly one cycle.
// The result is registered from the commit state, which returns the controller to
// idle, so busy is already low in the strobe cycle and a new reference can start then.
// The receiver cannot stall; each result must be taken in its strobe cycle.
// Register 0 (byte address 0), frames_in_use, is written over the APB port; the user must
// write it only while busy is low (the unit does not enforce this); 0 acts as 1 and values above 16 act as 16.
// Reset clears all frames, use counts, stamps and totals and sets frames_in_use
// to 16; the unit leaves reset idle and ready for a reference.
`timescale 1ns / 1ps
`default_nettype none
module lfu_page_replacement_unit
  import lfu_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [ADDR_BITS-1:0]  paddr,
  input  wire logic [DATA_BITS-1:0]  pwdata,
  output logic [DATA_BITS-1:0]       prdata,
  output logic                       pready,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [PAGE_BITS-1:0]  page_id_i,
  output logic                       res_valid_o,
  output logic                       hit_o,
  output logic [FRAME_BITS-1:0]      frame_index_o,
  output logic [COUNT_BITS-1:0]      fault_total_o,
  output logic [COUNT_BITS-1:0]      hit_total_o
);

  logic [CFG_BITS-1:0] frames_in_use_q;
  logic                reg_sel;
  lfu_cmd_t            cmd;
  lfu_sts_t            sts;
  logic                ctrl_busy;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[ADDR_BITS-1] == REG_FRAMES_IN_USE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_in_use_q <= FRAMES_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      frames_in_use_q <= pwdata[CFG_BITS-1:0];
    end
  end

  assign prdata = reg_sel ? DATA_BITS'(frames_in_use_q) : '0;

  lfu_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (ctrl_busy)
  );

  lfu_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .frames_in_use_i (frames_in_use_q),
    .page_id_i       (page_id_i),
    .res_valid_o     (res_valid_o),
    .hit_o           (hit_o),
    .frame_index_o   (frame_index_o),
    .fault_total_o   (fault_total_o),
    .hit_total_o     (hit_total_o)
  );

  assign busy = ctrl_busy;

endmodule
`default_nettype wire

// ----- src/lfu_checker.sv -----
// Port-level checks for the LFU page replacement unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lfu_checker
  import lfu_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  start,
  input wire logic                  busy,
  input wire logic                  res_valid_o,
  input wire logic                  hit_o,
  input wire logic [COUNT_BITS-1:0] fault_total_o
);

  // an accepted reference keeps the unit busy in the next cycle
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("start transfer did not raise busy");

  // a result strobe comes exactly when the unit leaves the busy state
  a_strobe_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> ($past(busy) && !busy))
    else $error("result strobe outside the end of a reference");

  a_done_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy && $past(busy)) |-> res_valid_o)
    else $error("reference finished without a result strobe");

  // one strobe per reference: never two in a row
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe held longer than one cycle");

  // when a hit follows a back-to-back earlier hit result, the fault total is unchanged from it
  a_hit_keeps_faults: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && hit_o && $past(res_valid_o, 3) && $past(hit_o, 3) &&
     ($past(fault_total_o, 3) == $past(fault_total_o))) |-> $stable(fault_total_o) ||
     (fault_total_o == $past(fault_total_o, 3)))
    else $error("fault total changed on a hit");

endmodule

bind lfu_page_replacement_unit lfu_checker u_lfu_checker (.*);
`default_nettype wire

// ----- tb/sv/lfu_page_replacement_unit_chk.sv -----
// Checker for the LFU page replacement unit: predicts each reference outcome and compares it.
`timescale 1ns / 1ps
`default_nettype none
module lfu_page_replacement_unit_chk
  import lfu_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel_i,
  input  wire logic                  penable_i,
  input  wire logic                  pwrite_i,
  input  wire logic                  pready_i,
  input  wire logic [ADDR_BITS-1:0]  paddr_i,
  input  wire logic [DATA_BITS-1:0]  pwdata_i,
  input  wire logic [DATA_BITS-1:0]  prdata_i,
  input  wire logic                  start_i,
  input  wire logic                  busy_i,
  input  wire logic [PAGE_BITS-1:0]  page_id_i,
  input  wire logic                  res_valid_i,
  input  wire logic                  hit_i,
  input  wire logic [FRAME_BITS-1:0] frame_index_i,
  input  wire logic [COUNT_BITS-1:0] fault_total_i,
  input  wire logic [COUNT_BITS-1:0] hit_total_i,
  output int                         mismatches_o,
  output int                         outstanding_o
);

  localparam logic [ADDR_BITS-1:0] FRAMES_ADDR = ADDR_BITS'(4 * REG_FRAMES_IN_USE);

  typedef struct packed {
    logic                  hit;
    logic [FRAME_BITS-1:0] frame;
    logic [COUNT_BITS-1:0] faults;
    logic [COUNT_BITS-1:0] hits;
  } outcome_t;

  logic [CFG_BITS-1:0]   frame_limit;
  logic [PAGE_BITS-1:0]  resident_page [MAX_FRAMES];
  logic                  resident      [MAX_FRAMES];
  logic [USES_BITS-1:0]  use_count     [MAX_FRAMES];
  logic [COUNT_BITS-1:0] arrival       [MAX_FRAMES];
  logic [COUNT_BITS-1:0] stamp_seq;
  logic [COUNT_BITS-1:0] fault_count;
  logic [COUNT_BITS-1:0] hit_count;
  outcome_t              predicted_outcomes [$];
  int                    mismatches = 0;

  // 0 behaves as one frame, anything above the table size as the full table
  function automatic int managed_frames();
    if (frame_limit == '0) return 1;
    if (frame_limit > CFG_BITS'(MAX_FRAMES)) return MAX_FRAMES;
    return int'(frame_limit);
  endfunction

  function automatic outcome_t place_reference(logic [PAGE_BITS-1:0] page);
    int       n;
    int       slot;
    bit       found;
    bit       empty;
    outcome_t res;
    n     = managed_frames();
    slot  = 0;
    found = 1'b0;
    empty = 1'b0;
    // lowest resident copy wins; hidden frames above the limit are skipped
    for (int i = 0; i < n; i++) begin
      if (!found && resident[i] && resident_page[i] == page) begin
        slot  = i;
        found = 1'b1;
      end
    end
    if (found) begin
      if (hit_count != '1) hit_count = hit_count + 1'b1;
      if (use_count[slot] != '1) use_count[slot] = use_count[slot] + 1'b1;
      if (arrival[slot] != '1) arrival[slot] = arrival[slot] + 1'b1;
    end else begin
      if (fault_count != '1) fault_count = fault_count + 1'b1;
      for (int i = 0; i < n; i++) begin
        if (!empty && !resident[i]) begin
          slot  = i;
          empty = 1'b1;
        end
      end
      if (!empty) begin
        // least used, then oldest stamp, then lowest index
        slot = 0;
        for (int i = 1; i < n; i++) begin
          if (use_count[i] < use_count[slot] ||
              (use_count[i] == use_count[slot] && arrival[i] < arrival[slot]))
            slot = i;
        end
      end
      if (stamp_seq != '1) stamp_seq = stamp_seq + 1'b1;
      resident_page[slot] = page;
      resident[slot]      = 1'b1;
      use_count[slot]     = USES_BITS'(1);
      arrival[slot]       = stamp_seq;
    end
    res.hit    = found;
    res.frame  = FRAME_BITS'(slot);
    res.faults = fault_count;
    res.hits   = hit_count;
    return res;
  endfunction

  function automatic int field_differs(string field, logic [COUNT_BITS-1:0] want_v,
                                       logic [COUNT_BITS-1:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want_v, got_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    outcome_t want;
    if (!rst_ni) begin
      frame_limit = FRAMES_RESET;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        resident_page[i] = '0;
        resident[i]      = 1'b0;
        use_count[i]     = '0;
        arrival[i]       = '0;
      end
      stamp_seq   = '0;
      fault_count = '0;
      hit_count   = '0;
      predicted_outcomes.delete();
    end else begin
      if (psel_i && penable_i && pready_i && paddr_i == FRAMES_ADDR) begin
        if (pwrite_i) begin
          frame_limit = pwdata_i[CFG_BITS-1:0];
        end else begin
          mismatches += field_differs("frames_in_use readback",
                                      COUNT_BITS'(frame_limit), prdata_i);
        end
      end
      // the strobe belongs to an earlier transfer, so retire it before predicting
      if (res_valid_i) begin
        if (predicted_outcomes.size() == 0) begin
          $display("%0t: result with none expected, expected nothing actual hit=%0h frame=%0h",
                   $time, hit_i, frame_index_i);
          mismatches++;
        end else begin
          want = predicted_outcomes.pop_front();
          mismatches += field_differs("hit", COUNT_BITS'(want.hit), COUNT_BITS'(hit_i));
          mismatches += field_differs("frame_index", COUNT_BITS'(want.frame),
                                      COUNT_BITS'(frame_index_i));
          mismatches += field_differs("fault_total", want.faults, fault_total_i);
          mismatches += field_differs("hit_total", want.hits, hit_total_i);
        end
      end
      if (start_i && !busy_i) predicted_outcomes.push_back(place_reference(page_id_i));
    end
    mismatches_o  <= mismatches;
    outstanding_o <= predicted_outcomes.size();
  end

endmodule
`default_nettype wire

// ----- tb/sv/lfu_page_replacement_unit_tb.sv -----
// Testbench top for the LFU page replacement unit: stimulus, register writes and verdict.
`timescale 1ns / 1ps
`default_nettype none
module lfu_page_replacement_unit_tb;
  import lfu_pkg::*;

  localparam int TIMEOUT_CYCLES = 300000;
  localparam int PHASE_ITEMS    = 55;
  localparam logic [ADDR_BITS-1:0] FRAMES_ADDR = ADDR_BITS'(4 * REG_FRAMES_IN_USE);

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [ADDR_BITS-1:0]  paddr     = '0;
  logic [DATA_BITS-1:0]  pwdata    = '0;
  logic [DATA_BITS-1:0]  prdata;
  logic                  pready;
  logic                  start     = 1'b0;
  logic                  busy;
  logic [PAGE_BITS-1:0]  page_id_i = '0;
  logic                  res_valid_o;
  logic                  hit_o;
  logic [FRAME_BITS-1:0] frame_index_o;
  logic [COUNT_BITS-1:0] fault_total_o;
  logic [COUNT_BITS-1:0] hit_total_o;

  int                    mismatches;
  int                    outstanding;
  int                    cycle_count = 0;
  int                    active_n    = MAX_FRAMES;
  logic [PAGE_BITS-1:0]  page_base;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  lfu_page_replacement_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .start         (start),
    .busy          (busy),
    .page_id_i     (page_id_i),
    .res_valid_o   (res_valid_o),
    .hit_o         (hit_o),
    .frame_index_o (frame_index_o),
    .fault_total_o (fault_total_o),
    .hit_total_o   (hit_total_o)
  );

  lfu_page_replacement_unit_chk i_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .pready_i      (pready),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .prdata_i      (prdata),
    .start_i       (start),
    .busy_i        (busy),
    .page_id_i     (page_id_i),
    .res_valid_i   (res_valid_o),
    .hit_i         (hit_o),
    .frame_index_i (frame_index_o),
    .fault_total_i (fault_total_o),
    .hit_total_i   (hit_total_o),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == TIMEOUT_CYCLES) begin
      $display("lfu_page_replacement_unit_tb NOT OK");
      $finish;
    end
  end

  // hold start low until every predicted outcome has been retired and the unit is idle
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0 || busy);
  endtask

  // keep start high across back-to-back transfers; drop it only for a gap
  task automatic send_page(logic [PAGE_BITS-1:0] page, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start     <= 1'b1;
    page_id_i <= page;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic apb_transfer(logic is_write, logic [DATA_BITS-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= FRAMES_ADDR;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_frames(int value);
    drain_results();
    apb_transfer(1'b1, DATA_BITS'(value));
    apb_transfer(1'b0, '0);
    active_n = (value == 0) ? 1 : ((value > MAX_FRAMES) ? MAX_FRAMES : value);
  endtask

  // mostly a pool a bit larger than the frame set, so hits and evictions both occur
  function automatic logic [PAGE_BITS-1:0] pick_page();
    if ($urandom_range(0, 9) == 0) return PAGE_BITS'($urandom());
    return PAGE_BITS'(page_base + $urandom_range(0, active_n + active_n / 2 + 1));
  endfunction

  initial begin : stimulus
    int  phase_frames [10];
    bit  idle_on;
    int  gap;
    phase_frames = '{16, 1, 4, 17, 8, 0, 31, 2, 12, 16};
    page_base    = PAGE_BITS'($urandom());
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill, hit, and the all-zero / all-one page numbers
    send_page(16'h0000, 0);
    send_page(16'hFFFF, 0);
    send_page(16'h0000, 0);
    send_page(16'hAAAA, 1);
    send_page(16'h5555, 0);
    // shrink: frame holding 16'h5555 drops out of view, forcing a replacement
    set_frames(3);
    send_page(16'h0000, 0);
    send_page(16'hFFFF, 0);
    send_page(16'hAAAA, 0);
    send_page(16'h5555, 0);
    send_page(16'h1234, 2);
    send_page(16'h5555, 0);
    // zero acts as a single frame
    set_frames(0);
    send_page(16'h0007, 0);
    send_page(16'h0007, 0);
    send_page(16'h0008, 0);
    // out-of-range limit; hidden frames come back with duplicates below them
    set_frames(31);
    send_page(16'h5555, 0);
    send_page(16'hFFFF, 3);
    send_page(16'h0007, 0);
    set_frames(17);
    send_page(16'h0008, 0);

    for (int p = 0; p < 10; p++) begin
      set_frames(phase_frames[p]);
      idle_on = (p % 3 != 2) && (p < 8);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 4 && i == PHASE_ITEMS / 2) drain_results();
        gap = (idle_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
        send_page(pick_page(), gap);
      end
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("lfu_page_replacement_unit_tb OK");
    end else begin
      $display("lfu_page_replacement_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
